// ----- hw/rtl/pls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// shared types, codes and sizes for the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count;
        logic                    empty_res;
    } t_out_item;

    typedef struct packed {
        logic                do_write;
        logic                do_insert;
        logic                do_remove;
        logic [CMP_W-1:0]    position;
        logic [DATA_W-1:0]   value;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/pls_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell
// one list slot: holds, loads, or shifts in from a neighbor
// ----------------------------------------------------------------------------
module pls_cell (
    input  logic                      i_clk,
    input  pls_pkg::t_cell_ctl        i_ctl,
    input  logic [pls_pkg::IDX_W-1:0] i_index,
    input  logic [pls_pkg::DATA_W-1:0] i_left,
    input  logic [pls_pkg::DATA_W-1:0] i_right,
    output logic [pls_pkg::DATA_W-1:0] o_entry,
    output logic [pls_pkg::DATA_W-1:0] o_read
);
    import pls_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [CMP_W-1:0]  idx;
    logic              at_pos;
    logic              past_pos;

    assign idx      = CMP_W'(i_index);
    assign at_pos   = (idx == i_ctl.position);
    assign past_pos = (idx > i_ctl.position);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_insert) begin
            if (at_pos) begin
                n_entry = i_ctl.value;
            end else if (past_pos) begin
                n_entry = i_left;
            end
        end else if (i_ctl.do_remove) begin
            if (at_pos || past_pos) begin
                n_entry = i_right;
            end
        end else if (i_ctl.do_write && at_pos) begin
            n_entry = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_read  = at_pos ? r_entry : '0;

endmodule

// ----- hw/rtl/pls_ctl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctl
// entry count, request checking and cell control
// ----------------------------------------------------------------------------
module pls_ctl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  pls_pkg::t_in_item           i_item,
    output pls_pkg::t_cell_ctl          o_ctl,
    output logic [1:0]                  o_status,
    output logic [pls_pkg::COUNT_W-1:0] o_count,
    output logic                        o_empty
);
    import pls_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt;
    logic [CMP_W-1:0] n_cnt_ext;
    logic [1:0]       status;
    logic             ok;

    assign pos = CMP_W'(i_item.position);
    assign cnt = CMP_W'(r_count);

    always_comb begin
        status = ST_OK;
        if (i_item.operation == OP_INSERT) begin
            if (r_count >= CNT_W'(CAPACITY)) begin
                status = ST_FULL;
            end else if (pos > cnt) begin
                status = ST_RANGE;
            end
        end else begin
            if (r_count == '0) begin
                status = ST_EMPTY;
            end else if (pos >= cnt) begin
                status = ST_RANGE;
            end
        end
    end

    assign ok = i_accept && (status == ST_OK);

    always_comb begin
        o_ctl.do_write  = ok && (i_item.operation == OP_WRITE);
        o_ctl.do_insert = ok && (i_item.operation == OP_INSERT);
        o_ctl.do_remove = ok && (i_item.operation == OP_REMOVE);
        o_ctl.position  = pos;
        o_ctl.value     = i_item.value;
    end

    always_comb begin
        n_count = r_count;
        if (o_ctl.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (o_ctl.do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign n_cnt_ext = CMP_W'(n_count);
    assign o_status  = status;
    assign o_count   = n_cnt_ext[COUNT_W-1:0];
    assign o_empty   = (n_count == '0);

endmodule

// ----- hw/rtl/positional_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed 32-bit values with positional access
// ----------------------------------------------------------------------------
// Each request reads, overwrites, inserts before or removes at a position and
// returns one result item in the next cycle: the value read, a status, the
// count after the request and an empty flag. The list lives in a row of
// CAPACITY cells; on insert every cell past the position takes its left
// neighbor, on remove every cell from the position on takes its right
// neighbor, all in the same cycle. An output register holds the result, and
// one item is taken per cycle except while it is full and stalled. Rejected
// requests change nothing. Entries beyond the count are never read.
module positional_list_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pls_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pls_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);
    import pls_pkg::*;

    t_cell_ctl          ctl;
    logic               accept;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic [DATA_W-1:0]  entry [CAPACITY];
    logic [DATA_W-1:0]  rd    [CAPACITY];
    logic [DATA_W-1:0]  rd_any;
    t_out_item          n_out_item;
    t_out_item          r_out_item;
    logic               r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    pls_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_ctl    (ctl),
        .o_status (status),
        .o_count  (count),
        .o_empty  (empty)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = ctl.value;
        end else begin : g_mid
            assign left = entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = entry[g];
        end else begin : g_inner
            assign right = entry[g+1];
        end
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (IDX_W'(g)),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[g]),
            .o_read  (rd[g])
        );
    end

    always_comb begin
        rd_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_any = rd_any | rd[k];
        end
    end

    always_comb begin
        n_out_item.read_value = ((i_in_item.operation == OP_READ) && (status == ST_OK))
                                ? rd_any : '0;
        n_out_item.status     = status;
        n_out_item.count      = count;
        n_out_item.empty_res  = empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hw/rtl/pls_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_chk
// port-level checks for the positional list store
// ----------------------------------------------------------------------------
module pls_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input pls_pkg::t_in_item  i_in_item,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input pls_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);
    import pls_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // every taken item yields a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("item taken without result");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // empty flag agrees with count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.empty_res == (o_out_item.count == '0)))
        else $error("empty flag disagrees with count");

    // rejected requests return zero
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |-> (o_out_item.read_value == '0))
        else $error("rejected item returned data");

endmodule

bind positional_list_store pls_chk u_pls_chk (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store testbench
// checks every result item of the list store against a local list model
// ----------------------------------------------------------------------------
// A queue of requests, filled by a directed opener and by random fill, drain
// and mixed sequences, feeds a clocked driver. Each accepted request runs
// through a local copy of the list, and the monitor compares every result
// item field by field with the oldest expected reply. Sender gaps and
// receiver stalls change across three phases.
module testbench;
    import pls_pkg::*;

    localparam int CAP = CAPACITY;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    t_in_item  request_q[$];
    t_out_item reply_q[$];

    logic signed [DATA_W-1:0] list_mem [CAP];
    int list_len = 0;
    int gen_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_n = 0;
    int accepted_n = 0;
    int checked_n = 0;
    int mismatch_n = 0;
    int peak_len = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    positional_list_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_out_item list_apply(t_in_item req);
        t_out_item rsp;
        int p;
        rsp = '0;
        rsp.status = ST_OK;
        p = req.position;
        if (req.operation == OP_INSERT) begin
            if (list_len >= CAP) begin
                rsp.status = ST_FULL;
            end else if (p > list_len) begin
                rsp.status = ST_RANGE;
            end else begin
                for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                list_mem[p] = req.value;
                list_len++;
            end
        end else if (list_len == 0) begin
            rsp.status = ST_EMPTY;
        end else if (p >= list_len) begin
            rsp.status = ST_RANGE;
        end else begin
            case (req.operation)
                OP_READ: begin
                    rsp.read_value = list_mem[p];
                end
                OP_WRITE: begin
                    list_mem[p] = req.value;
                end
                default: begin
                    for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            endcase
        end
        if (list_len > peak_len) peak_len = list_len;
        rsp.count = COUNT_W'(list_len);
        rsp.empty_res = (list_len == 0);
        return rsp;
    endfunction

    task automatic note_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_n++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                reply_q.push_back(list_apply(in_item));
                accepted_n++;
            end
            if (!in_valid || !in_stall) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item <= request_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (reply_q.size() == 0) begin
                note_mismatch("result item with no request outstanding");
            end else begin
                want = reply_q.pop_front();
                checked_n++;
                status_seen[want.status]++;
                if (out_item.read_value !== want.read_value)
                    note_mismatch($sformatf("read_value want %0d got %0d",
                                            want.read_value, out_item.read_value));
                if (out_item.status !== want.status)
                    note_mismatch($sformatf("status want %0d got %0d",
                                            want.status, out_item.status));
                if (out_item.count !== want.count)
                    note_mismatch($sformatf("count want %0d got %0d",
                                            want.count, out_item.count));
                if (out_item.empty_res !== want.empty_res)
                    note_mismatch($sformatf("empty_res want %0d got %0d",
                                            want.empty_res, out_item.empty_res));
            end
        end
        out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic queue_req(logic [1:0] op, int pos, logic signed [DATA_W-1:0] val);
        t_in_item r;
        r.operation = op;
        r.position = POS_W'(pos);
        r.value = val;
        request_q.push_back(r);
        queued_n++;
        if (op == OP_INSERT && gen_count < CAP && pos <= gen_count) gen_count++;
        if (op == OP_REMOVE && gen_count > 0 && pos < gen_count) gen_count--;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos(logic [1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, CAP);
        if (r < 16) return gen_count;
        if (op == OP_INSERT) return $urandom_range(0, gen_count);
        if (gen_count == 0) return $urandom_range(0, CAP);
        return $urandom_range(0, gen_count - 1);
    endfunction

    function automatic logic [1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 60) return OP_INSERT;
                if (r < 75) return OP_READ;
                if (r < 90) return OP_WRITE;
                return OP_REMOVE;
            end
            1: begin
                if (r < 55) return OP_REMOVE;
                if (r < 70) return OP_INSERT;
                if (r < 85) return OP_READ;
                return OP_WRITE;
            end
            default: return 2'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (request_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int target;
        int mode;
        int seg;
        logic [1:0] op;

        // empty list cases
        queue_req(OP_READ, 0, 0);
        queue_req(OP_WRITE, 0, 7);
        queue_req(OP_REMOVE, 0, 0);
        queue_req(OP_INSERT, 1, 9);
        // appends, front and middle inserts with extreme values
        queue_req(OP_INSERT, 0, {1'b0, {(DATA_W-1){1'b1}}});
        queue_req(OP_INSERT, 1, {1'b1, {(DATA_W-1){1'b0}}});
        queue_req(OP_INSERT, 0, '1);
        queue_req(OP_INSERT, 1, '0);
        // first, last, one past last, position equal to the capacity
        queue_req(OP_READ, 0, 0);
        queue_req(OP_READ, 3, 0);
        queue_req(OP_READ, 4, 0);
        queue_req(OP_READ, CAP, 0);
        queue_req(OP_WRITE, 3, 32'h5a5a_a5a5);
        queue_req(OP_WRITE, 4, 1);
        queue_req(OP_REMOVE, 4, 0);
        queue_req(OP_READ, 3, 0);
        queue_req(OP_REMOVE, 1, 0);
        queue_req(OP_REMOVE, 0, 0);
        queue_req(OP_REMOVE, 1, 0);
        queue_req(OP_READ, 0, 0);
        queue_req(OP_REMOVE, 0, 0);
        queue_req(OP_READ, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = queued_n + 577;
            // fill to capacity, then probe the full list
            while (gen_count < CAP) queue_req(OP_INSERT, $urandom_range(0, gen_count), rand_value());
            queue_req(OP_INSERT, $urandom_range(0, CAP), rand_value());
            queue_req(OP_READ, 0, 0);
            queue_req(OP_READ, CAP - 1, 0);
            queue_req(OP_WRITE, CAP - 1, rand_value());
            queue_req(OP_REMOVE, CAP, 0);
            while (queued_n < target - 40) begin
                mode = $urandom_range(0, 2);
                seg = $urandom_range(8, 40);
                for (int k = 0; k < seg; k++) begin
                    op = pick_op(mode);
                    queue_req(op, pick_pos(op), rand_value());
                end
            end
            // empty the list again
            while (gen_count > 0) queue_req(OP_REMOVE, $urandom_range(0, gen_count - 1), 0);
            queue_req(OP_REMOVE, $urandom_range(0, CAP), 0);
            queue_req(OP_READ, 0, 0);
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (reply_q.size() != 0) note_mismatch("expected result items never arrived");
        $display("%0d requests accepted, %0d results checked, longest list %0d of %0d",
                 accepted_n, checked_n, peak_len, CAP);
        $display("status mix: ok %0d, empty %0d, out of range %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_FULL]);
        if (mismatch_n == 0) begin
            $display("positional_list_store regression: pass");
        end else begin
            $display("positional_list_store regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d requests still queued, %0d results outstanding",
                 request_q.size(), reply_q.size());
        $display("positional_list_store regression: fail");
        $finish;
    end

endmodule
